>>> src/mrc_pkg.sv
// shared types, constants and the crc fold for the modbus rtu response checker
// no dependencies
package mrc_pkg;

	// widths fixed by the field ranges and the parameter ranges
	localparam int unsigned WIDX_MAX_W = 6;  // word index, up to 64 words
	localparam int unsigned WANT_MAX_W = 7;  // word count, up to 64 words

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_LSB  = 16'h0001;
	localparam logic [7:0]  FC_EXC   = 8'h80;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_CRC = 2'd1;
	localparam logic [1:0] ST_EXC = 2'd2;

	// result kinds
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
		logic [4:0] word_count;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  word_index;
		logic [15:0] word_value;
		logic [1:0]  status;
		logic        last;
	} out_item_t;

	// one classified byte handed from the front to the back
	typedef struct packed {
		logic                  first;   // frame start: clear store, take want
		logic [WANT_MAX_W-1:0] want;
		logic                  wr;      // byte lands in the word store
		logic                  hi;      // high byte of its word
		logic [WIDX_MAX_W-1:0] widx;
		logic [7:0]            data;
		logic                  done;    // frame ends with this item
		logic [1:0]            status;
	} q_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_WORD,
		B_STAT
	} back_state_t;

	// one byte folded into the reflected crc-16
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_LSB) != 16'h0000)
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> src/modbus_rtu_response_checker.sv
// Modbus RTU response checker, top level.
// Bytes of one response frame come in on rx_item, one item per byte, with
// frame_end set on the final byte and word_count sampled on the first byte.
// The front keeps a running CRC-16 (0xA001 reflected, start 0xFFFF) over all
// but the final two bytes and classifies the bytes the back needs into a
// four-entry queue. The back writes data bytes into a word store and, at
// frame end, emits the requested register words (on an OK frame) followed by
// one status item with last set: 0 ok, 1 CRC mismatch, 2 exception response.
// Input: one byte per cycle while the queue has room; rx_stall rises when the
// queue is full. The back pops one item a cycle while it is idle.
// Drain: each word passes a read state (one word store read at the drain
// index, registered read data) and then a word state that loads the output
// register; the status item follows in a status state.
// res_stall holds the output register; the back waits on it while the front
// keeps taking bytes until the queue fills.
// Reset clears the frame state, the queue and the output register; the word
// store has a valid bit per half word and needs no clearing pass.
// depends on mrc_pkg, mrc_front, mrc_queue, mrc_back
module modbus_rtu_response_checker #(
	parameter int unsigned MAX_FRAME = 64,
	parameter int unsigned MAX_WORDS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  mrc_pkg::in_item_t  rx_item,
	output logic               res_valid,
	input  logic               res_stall,
	output mrc_pkg::out_item_t res_item
);
	import mrc_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     q_full;
	logic     pop;
	logic     q_valid;
	q_entry_t q_entry;

	// byte intake and classification
	mrc_front #(
		.MAX_FRAME(MAX_FRAME),
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_item    (rx_item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// decoupling queue
	mrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.nonempty   (q_valid),
		.pop_entry  (q_entry)
	);

	// word store and result drain
	mrc_back #(
		.MAX_WORDS(MAX_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

>>> src/mrc_front.sv
// front part: takes frame bytes, runs the crc, classifies each item for the back
// depends on mrc_pkg
module mrc_front #(
	parameter int unsigned MAX_FRAME = 64,
	parameter int unsigned MAX_WORDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  mrc_pkg::in_item_t rx_item,
	output logic              push,
	output mrc_pkg::q_entry_t push_entry,
	input  logic              q_full
);
	import mrc_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_FRAME + 1);
	localparam int unsigned WANT_W = $clog2(MAX_WORDS + 1);

	logic [15:0]      crc_q;
	logic [7:0]       d0_q;
	logic [7:0]       d1_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       fn_q;

	logic             acc;
	logic             in_range;
	logic             first;
	logic [15:0]      crc_n;
	logic [7:0]       d0_n;
	logic [7:0]       d1_n;
	logic [7:0]       fn_n;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] rel;
	logic [CNT_W-1:0] wi;
	logic             wr;
	logic [WANT_W-1:0] want;
	logic [1:0]       status;

	assign rx_stall = q_full;
	assign acc      = rx_valid && !rx_stall;
	assign in_range = cnt_q < CNT_W'(MAX_FRAME);
	assign first    = cnt_q == '0;

	// state update for a byte inside the frame limit
	always_comb begin
		crc_n = crc_q;
		d0_n  = d0_q;
		d1_n  = d1_q;
		fn_n  = fn_q;
		cnt_n = cnt_q;
		if (in_range) begin
			if (cnt_q >= CNT_W'(2))
				crc_n = crc_fold(crc_q, d0_q);
			d0_n  = d1_q;
			d1_n  = rx_item.rx_byte;
			if (cnt_q == CNT_W'(1))
				fn_n = rx_item.rx_byte;
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	// word store position of this byte
	assign rel = cnt_q - CNT_W'(3);
	assign wi  = rel >> 1;
	assign wr  = in_range && (cnt_q >= CNT_W'(3)) && (32'(wi) < 32'(MAX_WORDS));

	// requested word count, saturated
	always_comb begin
		if (7'(rx_item.word_count) > 7'(MAX_WORDS))
			want = WANT_W'(MAX_WORDS);
		else
			want = WANT_W'(rx_item.word_count);
	end

	// frame verdict, crc mismatch ahead of exception
	always_comb begin
		status = ST_OK;
		if (cnt_n >= CNT_W'(4) && {d1_n, d0_n} != crc_n)
			status = ST_CRC;
		else if (cnt_n >= CNT_W'(3) && (fn_n & FC_EXC) != 8'h00)
			status = ST_EXC;
	end

	// classified item toward the queue
	always_comb begin
		push_entry.first  = first;
		push_entry.want   = WANT_MAX_W'(want);
		push_entry.wr     = wr;
		push_entry.hi     = !rel[0];
		push_entry.widx   = WIDX_MAX_W'(wi);
		push_entry.data   = rx_item.rx_byte;
		push_entry.done   = rx_item.frame_end;
		push_entry.status = status;
	end
	assign push = acc && (first || wr || rx_item.frame_end);

	// frame state, back to start after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			d0_q  <= '0;
			d1_q  <= '0;
			cnt_q <= '0;
			fn_q  <= '0;
		end else if (acc) begin
			if (rx_item.frame_end) begin
				crc_q <= CRC_INIT;
				d0_q  <= '0;
				d1_q  <= '0;
				cnt_q <= '0;
				fn_q  <= '0;
			end else begin
				crc_q <= crc_n;
				d0_q  <= d0_n;
				d1_q  <= d1_n;
				cnt_q <= cnt_n;
				fn_q  <= fn_n;
			end
		end
	end

endmodule

>>> src/mrc_queue.sv
// four-entry queue of classified items between the front and the back
// depends on mrc_pkg
module mrc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrc_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output mrc_pkg::q_entry_t pop_entry
);
	import mrc_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	q_entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full      = cnt_q == (PTR_W+1)'(DEPTH);
	assign nonempty  = cnt_q != '0;
	assign pop_entry = slot_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && nonempty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wp_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + PTR_W'(1);
			if (do_pop)
				rp_q <= rp_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

endmodule

>>> src/mrc_back.sv
// back part: keeps the word store, drains words and the status of each frame
// depends on mrc_pkg
module mrc_back #(
	parameter int unsigned MAX_WORDS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mrc_pkg::q_entry_t  q_entry,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output mrc_pkg::out_item_t res_item
);
	import mrc_pkg::*;

	localparam int unsigned IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned WANT_W = $clog2(MAX_WORDS + 1);

	back_state_t        state_q;
	back_state_t        state_n;
	logic [IDX_W-1:0]   idx_q;
	logic [WANT_W-1:0]  want_q;
	logic [1:0]         status_q;
	logic [MAX_WORDS-1:0] vhi_q;
	logic [MAX_WORDS-1:0] vlo_q;
	logic [7:0]         mem_hi [MAX_WORDS];
	logic [7:0]         mem_lo [MAX_WORDS];
	logic [7:0]         rd_hi_q;
	logic [7:0]         rd_lo_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               slot_free;
	logic [WANT_W-1:0]  want_eff;
	logic               idx_last;
	logic               load_word;
	logic               load_stat;
	logic [IDX_W-1:0]   widx;
	logic [15:0]        word;

	assign slot_free = !out_valid_q || !res_stall;
	assign want_eff  = q_entry.first ? WANT_W'(q_entry.want) : want_q;
	assign idx_last  = (WANT_W'(idx_q) + WANT_W'(1)) == want_q;
	assign widx      = IDX_W'(q_entry.widx);
	assign word      = {vhi_q[idx_q] ? rd_hi_q : 8'h00, vlo_q[idx_q] ? rd_lo_q : 8'h00};

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid && q_entry.done) begin
					if (q_entry.status == ST_OK && want_eff != '0)
						state_n = B_READ;
					else
						state_n = B_STAT;
				end
			end
			B_READ: state_n = B_WORD;
			B_WORD: begin
				if (slot_free)
					state_n = idx_last ? B_STAT : B_READ;
			end
			B_STAT: begin
				if (slot_free)
					state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop       = 1'b0;
		load_word = 1'b0;
		load_stat = 1'b0;
		case (state_q)
			B_IDLE:  pop       = q_valid;
			B_WORD:  load_word = slot_free;
			B_STAT:  load_stat = slot_free;
			default: pop       = 1'b0;
		endcase
	end

	// word store, read at the drain index
	always_ff @(posedge clk) begin
		if (pop && q_entry.wr) begin
			if (q_entry.hi)
				mem_hi[widx] <= q_entry.data;
			else
				mem_lo[widx] <= q_entry.data;
		end
		rd_hi_q <= mem_hi[idx_q];
		rd_lo_q <= mem_lo[idx_q];
	end

	// control state, valid bits cleared at frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			idx_q    <= '0;
			want_q   <= '0;
			status_q <= ST_OK;
			vhi_q    <= '0;
			vlo_q    <= '0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				if (q_entry.first) begin
					want_q <= WANT_W'(q_entry.want);
					vhi_q  <= '0;
					vlo_q  <= '0;
				end
				if (q_entry.wr) begin
					if (q_entry.hi)
						vhi_q[widx] <= 1'b1;
					else
						vlo_q[widx] <= 1'b1;
				end
				if (q_entry.done) begin
					status_q <= q_entry.status;
					idx_q    <= '0;
				end
			end
			if (load_word && !idx_last)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_word || load_stat)
			out_valid_q <= 1'b1;
		else if (!res_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			out_q.kind       <= KIND_WORD;
			out_q.word_index <= 4'(idx_q);
			out_q.word_value <= word;
			out_q.status     <= ST_OK;
			out_q.last       <= 1'b0;
		end else if (load_stat) begin
			out_q.kind       <= KIND_STATUS;
			out_q.word_index <= 4'd0;
			out_q.word_value <= 16'h0000;
			out_q.status     <= status_q;
			out_q.last       <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

endmodule
